FILE: sv/sync_length_checksum_deframer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync/length/checksum deframer
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset.
`define SLCD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deframer assertion failed");

// Check a property on every rising edge, reset included.
`define SLCD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("deframer assertion failed");

`else

`define SLCD_ASSERT(name, clk, rst_n, prop)
`define SLCD_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

FILE: sv/slcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package slcd_pkg;

  localparam int unsigned LENGTH_FIELD_BYTES = 4;

  localparam logic [7:0]  SYNC_FIRST    = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND   = 8'h55;
  localparam logic [31:0] MAX_LEN_RESET = 32'd250000;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  frame_type;
    logic [7:0]  payload_byte;
    logic [31:0] payload_index;
    logic [31:0] frame_length;
    logic        last;
  } result_t;

endpackage

FILE: sv/slcd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_parser
// Frame state machine: sync hunt, header capture, payload and checksum.
// ----------------------------------------------------------------------------
`include "sync_length_checksum_deframer_macros.svh"

module slcd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [31:0]          max_len_i,
  output logic                 res_valid_o,
  output slcd_pkg::result_t    res_o
);

  slcd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  held_type_q, held_type_d;
  logic [31:0] held_length_q, held_length_d;
  logic [2:0]  len_cnt_q, len_cnt_d;
  logic [31:0] payload_count_q, payload_count_d;
  logic [7:0]  sum_q, sum_d;

  logic [31:0] count_inc;
  logic [7:0]  sum_inc;
  logic [31:0] len_merged;
  logic        fin;

  assign count_inc  = payload_count_q + 32'd1;
  assign sum_inc    = sum_q + rx_byte_i;
  assign len_merged = held_length_q | ({24'd0, rx_byte_i} << {len_cnt_q[1:0], 3'b000});
  assign fin        = count_inc >= held_length_q;

  // Next state
  always_comb begin
    phase_d         = phase_q;
    held_type_d     = held_type_q;
    held_length_d   = held_length_q;
    len_cnt_d       = len_cnt_q;
    payload_count_d = payload_count_q;
    sum_d           = sum_q;
    if (fire_i) begin
      unique case (phase_q)
        slcd_pkg::PH_HUNT1: begin
          if (rx_byte_i == slcd_pkg::SYNC_FIRST) begin
            phase_d = slcd_pkg::PH_HUNT2;
          end
        end
        slcd_pkg::PH_HUNT2: begin
          phase_d = (rx_byte_i == slcd_pkg::SYNC_SECOND) ? slcd_pkg::PH_TYPE
                                                         : slcd_pkg::PH_HUNT1;
        end
        slcd_pkg::PH_TYPE: begin
          held_type_d   = rx_byte_i;
          held_length_d = '0;
          len_cnt_d     = '0;
          phase_d       = slcd_pkg::PH_LEN;
        end
        slcd_pkg::PH_LEN: begin
          held_length_d = len_merged;
          len_cnt_d     = len_cnt_q + 3'd1;
          if (len_cnt_d >= 3'(slcd_pkg::LENGTH_FIELD_BYTES)) begin
            payload_count_d = '0;
            sum_d           = '0;
            // drop empty and oversized frames
            if ((len_merged != 32'd0) && (len_merged <= max_len_i)) begin
              phase_d = slcd_pkg::PH_PAYLOAD;
            end else begin
              phase_d = slcd_pkg::PH_HUNT1;
            end
          end
        end
        slcd_pkg::PH_PAYLOAD: begin
          payload_count_d = count_inc;
          sum_d           = sum_inc;
          if (fin) begin
            phase_d = slcd_pkg::PH_CHECK;
          end
        end
        slcd_pkg::PH_CHECK: begin
          phase_d = slcd_pkg::PH_HUNT1;
        end
        default: begin
          phase_d = slcd_pkg::PH_HUNT1;
        end
      endcase
    end
  end

  // Result
  always_comb begin
    res_valid_o         = 1'b0;
    res_o.kind          = slcd_pkg::KIND_PAYLOAD;
    res_o.frame_type    = held_type_q;
    res_o.payload_byte  = '0;
    res_o.payload_index = '0;
    res_o.frame_length  = held_length_q;
    res_o.last          = 1'b0;
    unique case (phase_q)
      slcd_pkg::PH_PAYLOAD: begin
        res_valid_o         = fire_i;
        res_o.payload_byte  = rx_byte_i;
        res_o.payload_index = payload_count_q;
        res_o.last          = fin;
      end
      slcd_pkg::PH_CHECK: begin
        res_valid_o = fire_i;
        res_o.kind  = (rx_byte_i == sum_q) ? slcd_pkg::KIND_GOOD : slcd_pkg::KIND_BAD;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= slcd_pkg::PH_HUNT1;
      held_type_q     <= '0;
      held_length_q   <= '0;
      len_cnt_q       <= '0;
      payload_count_q <= '0;
      sum_q           <= '0;
    end else begin
      phase_q         <= phase_d;
      held_type_q     <= held_type_d;
      held_length_q   <= held_length_d;
      len_cnt_q       <= len_cnt_d;
      payload_count_q <= payload_count_d;
      sum_q           <= sum_d;
    end
  end

  `SLCD_ASSERT(a_payload_in_range, clk_i, rst_ni, (phase_q == slcd_pkg::PH_PAYLOAD) |-> (payload_count_q < held_length_q))
  `SLCD_ASSERT(a_last_to_check, clk_i, rst_ni, (res_valid_o && res_o.last) |=> (phase_q == slcd_pkg::PH_CHECK))
  `SLCD_ASSERT_ALWAYS(a_result_needs_item, clk_i, res_valid_o |-> fire_i)

endmodule

FILE: sv/slcd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_out_stage
// Result register with a skid entry, decoupling input and output stalls.
// ----------------------------------------------------------------------------
`include "sync_length_checksum_deframer_macros.svh"

module slcd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  slcd_pkg::result_t    push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  output slcd_pkg::result_t    out_data_o,
  input  logic                 out_stall_i
);

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  slcd_pkg::result_t main_q, main_d;
  slcd_pkg::result_t skid_q, skid_d;
  logic              out_fire;

  assign out_fire    = main_valid_q & ~out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // input is held off; drain the skid entry into the main register
      if (out_fire) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || out_fire) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  `SLCD_ASSERT(a_skid_behind_main, clk_i, rst_ni, skid_valid_q |-> main_valid_q)
  `SLCD_ASSERT(a_no_push_when_full, clk_i, rst_ni, skid_valid_q |-> !push_i)

endmodule

FILE: sv/sync_length_checksum_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Serial frame parser: sync 0xAA 0x55, type, little-endian length, payload
// bytes and an additive checksum, with a programmable length limit.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  rx      | rx_valid_i/rx_stall_o | rx_byte_i
//  res     | res_valid_o/res_stall_i | kind, frame_type, payload_byte,
//          |                       | payload_index, frame_length, last
//  cfg     | cfg_we_i              | cfg_wdata_i (max payload length)
//
//  One item per cycle while rx_stall_o is low; the frame state updates in the cycle an item is taken.
//  A taken item's result is registered in the output register or the skid entry.
//  A skid entry absorbs one result, so rx_stall_o rises only once two
//  results wait behind a stalled output.
//  Reset returns to sync hunting with the length limit at 250000.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  frame_type_o,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] payload_index_o,
  output logic [31:0] frame_length_o,
  output logic        last_o
);

  logic [31:0]       max_len_q;
  logic              rx_fire;
  logic              full;
  logic              res_push;
  slcd_pkg::result_t res_new;
  slcd_pkg::result_t res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= slcd_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  assign rx_stall_o = full;
  assign rx_fire    = rx_valid_i & ~full;

  slcd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (rx_fire),
    .rx_byte_i   (rx_byte_i),
    .max_len_i   (max_len_q),
    .res_valid_o (res_push),
    .res_o       (res_new)
  );

  slcd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_new),
    .full_o      (full),
    .out_valid_o (res_valid_o),
    .out_data_o  (res_out),
    .out_stall_i (res_stall_i)
  );

  assign kind_o          = res_out.kind;
  assign frame_type_o    = res_out.frame_type;
  assign payload_byte_o  = res_out.payload_byte;
  assign payload_index_o = res_out.payload_index;
  assign frame_length_o  = res_out.frame_length;
  assign last_o          = res_out.last;

endmodule
